// ----- design/dtpc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Depth to point cloud: shared types and constants
// Configuration record, job control word and register map of the block.
// ----------------------------------------------------------------------------
package dtpc_pkg;

  localparam int DIM_CFG_W   = 13;
  localparam int PARAM_W     = 16;
  localparam int DEPTH_W     = 16;
  localparam int COORD_W     = 24;
  localparam int COUNT_W     = 25;
  localparam int QUEUE_DEPTH = 2;
  localparam int REG_IDX_W   = 3;
  localparam int ADDR_W      = REG_IDX_W + 2;
  localparam int APB_DATA_W  = 32;

  localparam int COORD_MAX     = 8388607;
  localparam int COORD_MIN_MAG = 8388608;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // Register indexes on the configuration port.
  localparam logic [REG_IDX_W-1:0] REG_FRAME_WIDTH  = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_FRAME_HEIGHT = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_CENTER_X     = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_CENTER_Y     = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_FOCAL_X      = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_FOCAL_Y      = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_MIN_DEPTH    = 3'd6;

  localparam logic [DIM_CFG_W-1:0] RST_FRAME_WIDTH  = 13'd640;
  localparam logic [DIM_CFG_W-1:0] RST_FRAME_HEIGHT = 13'd480;
  localparam logic [PARAM_W-1:0]   RST_CENTER_X     = 16'd5120;
  localparam logic [PARAM_W-1:0]   RST_CENTER_Y     = 16'd3840;
  localparam logic [PARAM_W-1:0]   RST_FOCAL_X      = 16'd8000;
  localparam logic [PARAM_W-1:0]   RST_FOCAL_Y      = 16'd8000;
  localparam logic [PARAM_W-1:0]   RST_MIN_DEPTH    = 16'd0;

  typedef struct packed {
    logic [DIM_CFG_W-1:0] frame_width;
    logic [DIM_CFG_W-1:0] frame_height;
    logic [PARAM_W-1:0]   center_x;
    logic [PARAM_W-1:0]   center_y;
    logic [PARAM_W-1:0]   focal_x;
    logic [PARAM_W-1:0]   focal_y;
    logic [PARAM_W-1:0]   min_depth;
  } cfg_t;

  typedef struct packed {
    logic               point_valid;
    logic               frame_done;
    logic [COUNT_W-1:0] valid_count;
  } job_ctrl_t;

endpackage

// ----- design/depth_to_point_cloud_unit.sv -----
`timescale 1ns / 1ps
// A word that yields a point passes the queue and then the back end's multiply,
// divide and hold states; the quotient is the offset width plus 15 bits wide.
// The back end takes its next job only once the bit-serial divider is done and
// the result slot is free; dropped pixels cost the back end nothing.
// Reset clears the counters, the queue and the result slot; registers return
// to their defaults. No clearing pass is needed.
// ----------------------------------------------------------------------------
// Depth to point cloud unit
// Back-projects a raster stream of depth pixels into 3D points.
// ----------------------------------------------------------------------------
module depth_to_point_cloud_unit #(
  parameter int MAX_DIM = 4096
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [dtpc_pkg::ADDR_W-1:0]          paddr,
  input  logic [dtpc_pkg::APB_DATA_W-1:0]      pwdata,
  output logic [dtpc_pkg::APB_DATA_W-1:0]      prdata,
  output logic                                 pready,
  input  logic                                 push,
  output logic                                 full,
  input  logic [dtpc_pkg::DEPTH_W-1:0]         depth_i,
  output logic                                 empty,
  input  logic                                 pop,
  output logic signed [dtpc_pkg::COORD_W-1:0]  point_x_o,
  output logic signed [dtpc_pkg::COORD_W-1:0]  point_y_o,
  output logic [dtpc_pkg::DEPTH_W-1:0]         point_z_o,
  output logic                                 point_valid_o,
  output logic                                 frame_done_o,
  output logic [dtpc_pkg::COUNT_W-1:0]         valid_count_o
);
  import dtpc_pkg::*;

  localparam int IDX_W    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int SCALED_W = (IDX_W + 4 > PARAM_W) ? IDX_W + 4 : PARAM_W;
  localparam int DIFF_W   = SCALED_W + 1;
  localparam int JOB_W    = $bits(job_ctrl_t) + DEPTH_W + 2 * DIFF_W;

  cfg_t                     cfg_q;
  logic [REG_IDX_W-1:0]     reg_idx;
  logic                     wr_en;

  logic                     q_push, q_full, q_pop, q_empty;
  job_ctrl_t                f_ctrl, b_ctrl;
  logic [DEPTH_W-1:0]       f_depth, b_depth;
  logic signed [DIFF_W-1:0] f_diff_x, f_diff_y, b_diff_x, b_diff_y;
  logic [JOB_W-1:0]         q_wdata, q_rdata;

  assign pready  = 1'b1;
  assign reg_idx = paddr[ADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.frame_width  <= RST_FRAME_WIDTH;
      cfg_q.frame_height <= RST_FRAME_HEIGHT;
      cfg_q.center_x     <= RST_CENTER_X;
      cfg_q.center_y     <= RST_CENTER_Y;
      cfg_q.focal_x      <= RST_FOCAL_X;
      cfg_q.focal_y      <= RST_FOCAL_Y;
      cfg_q.min_depth    <= RST_MIN_DEPTH;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_FRAME_WIDTH:  cfg_q.frame_width  <= pwdata[DIM_CFG_W-1:0];
        REG_FRAME_HEIGHT: cfg_q.frame_height <= pwdata[DIM_CFG_W-1:0];
        REG_CENTER_X:     cfg_q.center_x     <= pwdata[PARAM_W-1:0];
        REG_CENTER_Y:     cfg_q.center_y     <= pwdata[PARAM_W-1:0];
        REG_FOCAL_X:      cfg_q.focal_x      <= pwdata[PARAM_W-1:0];
        REG_FOCAL_Y:      cfg_q.focal_y      <= pwdata[PARAM_W-1:0];
        REG_MIN_DEPTH:    cfg_q.min_depth    <= pwdata[PARAM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_FRAME_WIDTH:  prdata = APB_DATA_W'(cfg_q.frame_width);
      REG_FRAME_HEIGHT: prdata = APB_DATA_W'(cfg_q.frame_height);
      REG_CENTER_X:     prdata = APB_DATA_W'(cfg_q.center_x);
      REG_CENTER_Y:     prdata = APB_DATA_W'(cfg_q.center_y);
      REG_FOCAL_X:      prdata = APB_DATA_W'(cfg_q.focal_x);
      REG_FOCAL_Y:      prdata = APB_DATA_W'(cfg_q.focal_y);
      REG_MIN_DEPTH:    prdata = APB_DATA_W'(cfg_q.min_depth);
      default:          prdata = '0;
    endcase
  end

  dtpc_front #(
    .MAX_DIM (MAX_DIM),
    .DIFF_W  (DIFF_W)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .push_i     (push),
    .depth_i    (depth_i),
    .full_o     (full),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_ctrl_o   (f_ctrl),
    .q_depth_o  (f_depth),
    .q_diff_x_o (f_diff_x),
    .q_diff_y_o (f_diff_y)
  );

  assign q_wdata = {f_ctrl, f_depth, f_diff_x, f_diff_y};
  assign {b_ctrl, b_depth, b_diff_x, b_diff_y} = q_rdata;

  dtpc_queue #(
    .DATA_W (JOB_W)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_wdata),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .data_o  (q_rdata),
    .empty_o (q_empty)
  );

  dtpc_back #(
    .DIFF_W (DIFF_W)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .q_empty_i     (q_empty),
    .q_pop_o       (q_pop),
    .q_ctrl_i      (b_ctrl),
    .q_depth_i     (b_depth),
    .q_diff_x_i    (b_diff_x),
    .q_diff_y_i    (b_diff_y),
    .empty_o       (empty),
    .pop_i         (pop),
    .point_x_o     (point_x_o),
    .point_y_o     (point_y_o),
    .point_z_o     (point_z_o),
    .point_valid_o (point_valid_o),
    .frame_done_o  (frame_done_o),
    .valid_count_o (valid_count_o)
  );

endmodule

// ----- design/dtpc_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Depth to point cloud: front end
// Accepts depth words, tracks column, row and point count, drops invalid
// pixels that do not end a frame and queues the rest with their offsets.
// ----------------------------------------------------------------------------
module dtpc_front #(
  parameter int MAX_DIM = 4096,
  parameter int DIFF_W  = 17
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  dtpc_pkg::cfg_t                cfg_i,
  input  logic                          push_i,
  input  logic [dtpc_pkg::DEPTH_W-1:0]  depth_i,
  output logic                          full_o,
  input  logic                          q_full_i,
  output logic                          q_push_o,
  output dtpc_pkg::job_ctrl_t           q_ctrl_o,
  output logic [dtpc_pkg::DEPTH_W-1:0]  q_depth_o,
  output logic signed [DIFF_W-1:0]      q_diff_x_o,
  output logic signed [DIFF_W-1:0]      q_diff_y_o
);
  import dtpc_pkg::*;

  localparam int IDX_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int DIM_W = (IDX_W + 1 > DIM_CFG_W) ? IDX_W + 1 : DIM_CFG_W;

  logic [IDX_W-1:0]   column_q, column_d;
  logic [IDX_W-1:0]   row_q, row_d;
  logic [COUNT_W-1:0] points_q, points_d;

  logic [DIM_W-1:0]   last_col, last_row;
  logic               accept, row_end, frame_end, pix_valid;
  logic [COUNT_W-1:0] count;

  // Zero acts as one and anything above the maximum acts as the maximum.
  function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_CFG_W-1:0] d);
    logic [DIM_W-1:0] dx;
    dx = DIM_W'(d);
    if (dx == '0) begin
      return DIM_W'(1);
    end else if (dx > DIM_W'(MAX_DIM)) begin
      return DIM_W'(MAX_DIM);
    end
    return dx;
  endfunction

  assign last_col  = eff_dim(cfg_i.frame_width) - DIM_W'(1);
  assign last_row  = eff_dim(cfg_i.frame_height) - DIM_W'(1);
  assign row_end   = DIM_W'(column_q) >= last_col;
  assign frame_end = row_end && (DIM_W'(row_q) >= last_row);
  assign pix_valid = depth_i > cfg_i.min_depth;
  assign accept    = push_i && !q_full_i;
  assign full_o    = q_full_i;

  always_comb begin
    count = points_q;
    if (pix_valid && (points_q != COUNT_MAX)) begin
      count = points_q + COUNT_W'(1);
    end
    column_d = column_q + IDX_W'(1);
    row_d    = row_q;
    points_d = count;
    if (frame_end) begin
      column_d = '0;
      row_d    = '0;
      points_d = '0;
    end else if (row_end) begin
      column_d = '0;
      row_d    = row_q + IDX_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      column_q <= '0;
      row_q    <= '0;
      points_q <= '0;
    end else if (accept) begin
      column_q <= column_d;
      row_q    <= row_d;
      points_q <= points_d;
    end
  end

  assign q_push_o             = accept && (pix_valid || frame_end);
  assign q_ctrl_o.point_valid = pix_valid;
  assign q_ctrl_o.frame_done  = frame_end;
  assign q_ctrl_o.valid_count = count;
  assign q_depth_o            = depth_i;
  // Pixel index in Q12.4 less the principal point, as a signed offset.
  assign q_diff_x_o = DIFF_W'({column_q, 4'b0000}) - DIFF_W'(cfg_i.center_x);
  assign q_diff_y_o = DIFF_W'({row_q, 4'b0000}) - DIFF_W'(cfg_i.center_y);

endmodule

// ----- design/dtpc_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Depth to point cloud: job queue
// Short register queue that decouples the front end from the divider.
// ----------------------------------------------------------------------------
module dtpc_queue #(
  parameter int DATA_W = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  logic [DATA_W-1:0] data_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic [DATA_W-1:0] data_o,
  output logic              empty_o
);
  import dtpc_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [DATA_W-1:0] slot_q [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0]  fill_q;
  logic              do_push, do_pop;

  assign full_o  = fill_q == CNT_W'(QUEUE_DEPTH);
  assign empty_o = fill_q == '0;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = slot_q[rd_ptr_q];

  function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
    if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
      return '0;
    end
    return p + PTR_W'(1);
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= next_ptr(wr_ptr_q);
      end
      if (do_pop) begin
        rd_ptr_q <= next_ptr(rd_ptr_q);
      end
      if (do_push && !do_pop) begin
        fill_q <= fill_q + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        fill_q <= fill_q - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ----- design/dtpc_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Depth to point cloud: back end
// Multiplies the offsets by depth, divides both products by the focal
// lengths one quotient bit a cycle, saturates and holds the result word.
// ----------------------------------------------------------------------------
module dtpc_back #(
  parameter int DIFF_W = 17
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  dtpc_pkg::cfg_t                      cfg_i,
  input  logic                                q_empty_i,
  output logic                                q_pop_o,
  input  dtpc_pkg::job_ctrl_t                 q_ctrl_i,
  input  logic [dtpc_pkg::DEPTH_W-1:0]        q_depth_i,
  input  logic signed [DIFF_W-1:0]            q_diff_x_i,
  input  logic signed [DIFF_W-1:0]            q_diff_y_i,
  output logic                                empty_o,
  input  logic                                pop_i,
  output logic signed [dtpc_pkg::COORD_W-1:0] point_x_o,
  output logic signed [dtpc_pkg::COORD_W-1:0] point_y_o,
  output logic [dtpc_pkg::DEPTH_W-1:0]        point_z_o,
  output logic                                point_valid_o,
  output logic                                frame_done_o,
  output logic [dtpc_pkg::COUNT_W-1:0]        valid_count_o
);
  import dtpc_pkg::*;

  localparam int PROD_W = DIFF_W + DEPTH_W + 1;
  localparam int MAG_W  = DIFF_W + DEPTH_W - 1;
  localparam int CNT_W  = $clog2(MAG_W);
  localparam int REM_W  = PARAM_W + 1;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MUL  = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_HOLD = 4'b1000
  } state_e;

  state_e state_q, state_d;

  job_ctrl_t                 ctrl_q;
  logic [DEPTH_W-1:0]        depth_q;
  logic signed [DIFF_W-1:0]  diff_x_q, diff_y_q;
  logic [MAG_W-1:0]          mag_x_q, mag_y_q;
  logic [PARAM_W-1:0]        rem_x_q, rem_y_q;
  logic                      neg_x_q, neg_y_q, zero_x_q, zero_y_q;
  logic [CNT_W-1:0]          cnt_q;

  logic signed [PROD_W-1:0]  prod_x, prod_y;
  logic [PROD_W-1:0]         abs_x, abs_y;
  logic [REM_W-1:0]          trial_x, trial_y;
  logic                      qbit_x, qbit_y;
  logic                      out_free, load_out;

  logic                      out_valid_q;
  logic signed [COORD_W-1:0] out_x_q, out_y_q;
  logic [DEPTH_W-1:0]        out_z_q;
  job_ctrl_t                 out_ctrl_q;

  assign prod_x = PROD_W'(diff_x_q) * $signed({1'b0, depth_q});
  assign prod_y = PROD_W'(diff_y_q) * $signed({1'b0, depth_q});
  assign abs_x  = prod_x[PROD_W-1] ? PROD_W'(-prod_x) : PROD_W'(prod_x);
  assign abs_y  = prod_y[PROD_W-1] ? PROD_W'(-prod_y) : PROD_W'(prod_y);

  // Restoring step: the dividend bits leave the top of the magnitude
  // register while the quotient bits enter at the bottom.
  assign trial_x = {rem_x_q, mag_x_q[MAG_W-1]};
  assign trial_y = {rem_y_q, mag_y_q[MAG_W-1]};
  assign qbit_x  = trial_x >= REM_W'(cfg_i.focal_x);
  assign qbit_y  = trial_y >= REM_W'(cfg_i.focal_y);

  // A zero focal length yields an all-ones quotient, which saturates.
  function automatic logic [COORD_W-1:0] sat_coord(input logic neg, input logic zero,
                                                   input logic [MAG_W-1:0] q);
    if (zero) begin
      return '0;
    end else if (neg) begin
      if (q > MAG_W'(COORD_MIN_MAG)) begin
        return COORD_W'(COORD_MIN_MAG);
      end
      return -q[COORD_W-1:0];
    end else if (q > MAG_W'(COORD_MAX)) begin
      return COORD_W'(COORD_MAX);
    end
    return q[COORD_W-1:0];
  endfunction

  assign out_free = !out_valid_q || pop_i;
  assign load_out = (state_q == ST_HOLD) && out_free;
  assign q_pop_o  = (state_q == ST_IDLE) && !q_empty_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (!q_empty_i) begin
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        state_d = ctrl_q.point_valid ? ST_DIV : ST_HOLD;
      end
      ST_DIV: begin
        if (cnt_q == CNT_W'(MAG_W - 1)) begin
          state_d = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (pop_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      ctrl_q   <= q_ctrl_i;
      depth_q  <= q_depth_i;
      diff_x_q <= q_diff_x_i;
      diff_y_q <= q_diff_y_i;
    end
    if (state_q == ST_MUL) begin
      mag_x_q  <= abs_x[MAG_W-1:0];
      mag_y_q  <= abs_y[MAG_W-1:0];
      neg_x_q  <= prod_x[PROD_W-1];
      neg_y_q  <= prod_y[PROD_W-1];
      zero_x_q <= !ctrl_q.point_valid || (prod_x == '0);
      zero_y_q <= !ctrl_q.point_valid || (prod_y == '0);
      rem_x_q  <= '0;
      rem_y_q  <= '0;
      cnt_q    <= '0;
    end
    if (state_q == ST_DIV) begin
      rem_x_q <= qbit_x ? PARAM_W'(trial_x - REM_W'(cfg_i.focal_x)) : PARAM_W'(trial_x);
      rem_y_q <= qbit_y ? PARAM_W'(trial_y - REM_W'(cfg_i.focal_y)) : PARAM_W'(trial_y);
      mag_x_q <= {mag_x_q[MAG_W-2:0], qbit_x};
      mag_y_q <= {mag_y_q[MAG_W-2:0], qbit_y};
      cnt_q   <= cnt_q + CNT_W'(1);
    end
    if (load_out) begin
      out_x_q    <= sat_coord(neg_x_q, zero_x_q, mag_x_q);
      out_y_q    <= sat_coord(neg_y_q, zero_y_q, mag_y_q);
      out_z_q    <= ctrl_q.point_valid ? depth_q : '0;
      out_ctrl_q <= ctrl_q;
    end
  end

  assign empty_o       = !out_valid_q;
  assign point_x_o     = out_x_q;
  assign point_y_o     = out_y_q;
  assign point_z_o     = out_z_q;
  assign point_valid_o = out_ctrl_q.point_valid;
  assign frame_done_o  = out_ctrl_q.frame_done;
  assign valid_count_o = out_ctrl_q.valid_count;

endmodule

// ----- design/dtpc_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Depth to point cloud: port checker
// Watches the result queue and configuration port of the top level.
// ----------------------------------------------------------------------------
module dtpc_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                pready,
  input logic                                empty,
  input logic                                pop,
  input logic signed [dtpc_pkg::COORD_W-1:0] point_x_o,
  input logic signed [dtpc_pkg::COORD_W-1:0] point_y_o,
  input logic [dtpc_pkg::DEPTH_W-1:0]        point_z_o,
  input logic                                point_valid_o,
  input logic                                frame_done_o,
  input logic [dtpc_pkg::COUNT_W-1:0]        valid_count_o
);

  // A waiting word that is not taken stays put.
  a_hold_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty && $stable(point_x_o) && $stable(point_y_o)
      && $stable(point_z_o) && $stable(valid_count_o))
    else $error("result word changed while waiting");

  // A word without a point only ever closes a frame, with zero coordinates.
  a_empty_point: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !point_valid_o |-> frame_done_o && point_x_o == '0
      && point_y_o == '0 && point_z_o == '0)
    else $error("pointless word that is not an all-zero frame end");

  // A point has nonzero depth, as it lies above the floor, and has been counted.
  a_point_counted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && point_valid_o |-> point_z_o != '0 && valid_count_o != '0)
    else $error("point with zero depth or zero count");

  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("configuration port not ready");

endmodule

bind depth_to_point_cloud_unit dtpc_checker u_dtpc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .pready        (pready),
  .empty         (empty),
  .pop           (pop),
  .point_x_o     (point_x_o),
  .point_y_o     (point_y_o),
  .point_z_o     (point_z_o),
  .point_valid_o (point_valid_o),
  .frame_done_o  (frame_done_o),
  .valid_count_o (valid_count_o)
);
